/* rtl/fsc_pkg.sv */
// filename safety checker package: item and result types, reason codes,
// byte constants and byte classification functions
// used by every module of the block
`default_nettype none

package fsc_pkg;

  typedef struct packed {
    logic [7:0] char_value;
    logic       last;
    logic       is_empty;
  } in_item_t;

  typedef struct packed {
    logic       safe;
    logic [2:0] reason;
  } out_item_t;

  typedef struct packed {
    logic      produce;
    out_item_t verdict;
  } scan_res_t;

  localparam logic [2:0] REASON_OK        = 3'd0;
  localparam logic [2:0] REASON_EMPTY     = 3'd1;
  localparam logic [2:0] REASON_TRAILING  = 3'd2;
  localparam logic [2:0] REASON_LEAD_SEP  = 3'd3;
  localparam logic [2:0] REASON_DRIVE     = 3'd4;
  localparam logic [2:0] REASON_DOT_PAIR  = 3'd5;
  localparam logic [2:0] REASON_DEVICE    = 3'd6;
  localparam logic [2:0] REASON_FORBIDDEN = 3'd7;

  localparam logic [2:0] CNT_MAX = 3'd7;
  localparam logic [2:0] STEM_LEN_DEV = 3'd3;
  localparam logic [2:0] STEM_LEN_PORT = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

  localparam logic [23:0] DEV_CON = "CON";
  localparam logic [23:0] DEV_PRN = "PRN";
  localparam logic [23:0] DEV_AUX = "AUX";
  localparam logic [23:0] DEV_NUL = "NUL";
  localparam logic [23:0] DEV_COM = "COM";
  localparam logic [23:0] DEV_LPT = "LPT";

  function automatic logic [7:0] upper_of(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c inside {[8'h61:8'h7a]}) begin
      u = c - 8'h20;
    end
    return u;
  endfunction

  function automatic logic byte_forbidden(input logic [7:0] c);
    return (c inside {8'h2a, 8'h22, 8'h2f, 8'h5c, 8'h3c, 8'h3e, 8'h3a, 8'h7c, 8'h3f})
           || (c < CH_CTRL_LIMIT);
  endfunction

  function automatic logic stem_is(input logic [3:0][7:0] s, input logic [23:0] w);
    return (upper_of(s[0]) == w[23:16]) && (upper_of(s[1]) == w[15:8]) &&
           (upper_of(s[2]) == w[7:0]);
  endfunction

endpackage

`default_nettype wire

/* rtl/fsc_in_stage.sv */
// input register stage: holds one item until the scan stage takes it
// depends on fsc_pkg
`default_nettype none

module fsc_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fsc_pkg::in_item_t in_data,
  input  wire logic             adv,
  output logic                  s1_valid,
  output fsc_pkg::in_item_t     s1_item
);

  logic              s1_valid_r, s1_valid_nxt;
  fsc_pkg::in_item_t s1_item_r;
  logic              accept;

  assign in_stall = s1_valid_r & ~adv;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r & ~adv;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

`default_nettype wire

/* rtl/fsc_scan.sv */
// per-name scan state: sticky check flags, stem capture and the verdict
// depends on fsc_pkg
`default_nettype none

module fsc_scan (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fsc_pkg::in_item_t item,
  input  wire logic              commit,
  output fsc_pkg::scan_res_t     res
);

  logic [2:0]      pos_r, pos_nxt;
  logic [2:0]      len_r, len_nxt;
  logic            stem_done_r, stem_done_nxt;
  logic [3:0][7:0] stem_r, stem_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic            lead_r, lead_nxt;
  logic            colon_r, colon_nxt;
  logic            dpair_r, dpair_nxt;
  logic            forb_r, forb_nxt;
  logic [7:0]      c;
  logic            reserved;
  logic [2:0]      reason;
  logic            clear;

  assign c = item.char_value;

  always_comb begin
    lead_nxt  = lead_r | ((pos_r == 3'd0) & ((c == fsc_pkg::CH_SLASH) | (c == fsc_pkg::CH_BSL)));
    colon_nxt = colon_r | ((pos_r == 3'd1) & (c == fsc_pkg::CH_COLON));
    dpair_nxt = dpair_r | ((pos_r != 3'd0) & (prev_r == fsc_pkg::CH_DOT) &
                           (c == fsc_pkg::CH_DOT));
    forb_nxt  = forb_r | fsc_pkg::byte_forbidden(c);
    stem_done_nxt = stem_done_r;
    stem_nxt      = stem_r;
    len_nxt       = len_r;
    if (!stem_done_r) begin
      if (c == fsc_pkg::CH_DOT) begin
        stem_done_nxt = 1'b1;
      end else begin
        if (len_r < fsc_pkg::STEM_LEN_PORT) begin
          stem_nxt[len_r[1:0]] = c;
        end
        if (len_r < fsc_pkg::CNT_MAX) begin
          len_nxt = len_r + 3'd1;
        end
      end
    end
    prev_nxt = c;
    pos_nxt  = (pos_r < fsc_pkg::CNT_MAX) ? pos_r + 3'd1 : pos_r;

    reserved = 1'b0;
    if (len_nxt == fsc_pkg::STEM_LEN_DEV) begin
      reserved = fsc_pkg::stem_is(stem_nxt, fsc_pkg::DEV_CON) |
                 fsc_pkg::stem_is(stem_nxt, fsc_pkg::DEV_PRN) |
                 fsc_pkg::stem_is(stem_nxt, fsc_pkg::DEV_AUX) |
                 fsc_pkg::stem_is(stem_nxt, fsc_pkg::DEV_NUL);
    end else if ((len_nxt == fsc_pkg::STEM_LEN_PORT) && (stem_nxt[3] inside {["1":"9"]})) begin
      reserved = fsc_pkg::stem_is(stem_nxt, fsc_pkg::DEV_COM) |
                 fsc_pkg::stem_is(stem_nxt, fsc_pkg::DEV_LPT);
    end

    if (item.is_empty) begin
      reason = fsc_pkg::REASON_EMPTY;
    end else if ((c == fsc_pkg::CH_SPACE) || (c == fsc_pkg::CH_DOT)) begin
      reason = fsc_pkg::REASON_TRAILING;
    end else if (lead_nxt) begin
      reason = fsc_pkg::REASON_LEAD_SEP;
    end else if (colon_nxt) begin
      reason = fsc_pkg::REASON_DRIVE;
    end else if (dpair_nxt) begin
      reason = fsc_pkg::REASON_DOT_PAIR;
    end else if (reserved) begin
      reason = fsc_pkg::REASON_DEVICE;
    end else if (forb_nxt) begin
      reason = fsc_pkg::REASON_FORBIDDEN;
    end else begin
      reason = fsc_pkg::REASON_OK;
    end

    clear              = item.last | item.is_empty;
    res.produce        = clear;
    res.verdict.reason = reason;
    res.verdict.safe   = (reason == fsc_pkg::REASON_OK);
  end

  // stem bytes are only read when the stem count says they were written
  always_ff @(posedge clk) begin
    if (commit) begin
      stem_r <= stem_nxt;
      prev_r <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      len_r       <= '0;
      stem_done_r <= 1'b0;
      lead_r      <= 1'b0;
      colon_r     <= 1'b0;
      dpair_r     <= 1'b0;
      forb_r      <= 1'b0;
    end else if (commit) begin
      if (clear) begin
        pos_r       <= '0;
        len_r       <= '0;
        stem_done_r <= 1'b0;
        lead_r      <= 1'b0;
        colon_r     <= 1'b0;
        dpair_r     <= 1'b0;
        forb_r      <= 1'b0;
      end else begin
        pos_r       <= pos_nxt;
        len_r       <= len_nxt;
        stem_done_r <= stem_done_nxt;
        lead_r      <= lead_nxt;
        colon_r     <= colon_nxt;
        dpair_r     <= dpair_nxt;
        forb_r      <= forb_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/fsc_out_stage.sv */
// result register: holds one verdict until the receiver takes it
// depends on fsc_pkg
`default_nettype none

module fsc_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire fsc_pkg::out_item_t res,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fsc_pkg::out_item_t      out_data
);

  logic               out_valid_r, out_valid_nxt;
  fsc_pkg::out_item_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/filename_safety_checker.sv */
// filename safety checker top level: input register, scan stage, result register
// depends on fsc_pkg, fsc_in_stage, fsc_scan, fsc_out_stage
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   fsc_pkg::in_item_t
//   out      output     out_valid / out_stall fsc_pkg::out_item_t
//
// one item per cycle sustained while no final item waits on the result register; a final
// item goes through the input register, then scan logic into the result register
// reset clears the name counters, the check flags and both valid flags
// an item with no verdict always leaves the input register; a final item waits
// there only while the result register holds an untaken verdict
`default_nettype none

module filename_safety_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fsc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fsc_pkg::out_item_t      out_data
);

  logic               s1_valid;
  fsc_pkg::in_item_t  s1_item;
  fsc_pkg::scan_res_t scan_res;
  logic               adv;
  logic               commit;
  logic               load;

  assign adv    = ~scan_res.produce | ~out_valid | ~out_stall;
  assign commit = s1_valid & adv;
  assign load   = commit & scan_res.produce;

  fsc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  fsc_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (s1_item),
    .commit (commit),
    .res    (scan_res)
  );

  fsc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (scan_res.verdict),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/fsc_checker.sv */
// port-level checks for the filename safety checker, bound to the top level
// depends on fsc_pkg and filename_safety_checker
`default_nettype none

module fsc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire fsc_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire fsc_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

  a_safe_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.safe == (out_data.reason == fsc_pkg::REASON_OK)))
    else $error("safe flag disagrees with reason");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  a_empty_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.is_empty ##1 !out_stall
    |=> out_valid && (out_data.reason == fsc_pkg::REASON_EMPTY))
    else $error("empty name verdict missing");

endmodule

bind filename_safety_checker fsc_checker u_fsc_checker (.*);

`default_nettype wire

/* tb/sv/fsc_verdict_checker.sv */
// verdict checker for the filename safety checker: follows both channels, predicts
// the verdict of each name from the items taken in and compares the verdicts given out
// depends on fsc_pkg
module fsc_verdict_checker import fsc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  output int             mismatches,
  output int             verdicts_pending
);

  logic [2:0] name_pos;
  logic [2:0] stem_cnt;
  logic       stem_closed;
  logic [7:0] stem [0:3];
  logic [7:0] prior_byte;
  logic       lead_sep, colon_second, dot_run, bad_byte_seen;
  out_item_t  verdicts_due[$];
  out_item_t  want;

  initial begin
    mismatches = 0;
    verdicts_pending = 0;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
  endfunction

  function automatic logic is_bad_byte(input logic [7:0] c);
    case (c)
      8'h2a, 8'h22, CH_SLASH, CH_BSL, 8'h3c, 8'h3e, CH_COLON, 8'h7c, 8'h3f: return 1'b1;
      default: return c < 8'h20;
    endcase
  endfunction

  function automatic logic stem_matches(input logic [23:0] w);
    return fold_case(stem[0]) == w[23:16] && fold_case(stem[1]) == w[15:8] &&
           fold_case(stem[2]) == w[7:0];
  endfunction

  function automatic logic device_stem();
    if (stem_cnt == 3'd3) begin
      return stem_matches(DEV_CON) || stem_matches(DEV_PRN) ||
             stem_matches(DEV_AUX) || stem_matches(DEV_NUL);
    end
    if (stem_cnt == 3'd4 && stem[3] >= 8'h31 && stem[3] <= 8'h39) begin
      return stem_matches(DEV_COM) || stem_matches(DEV_LPT);
    end
    return 1'b0;
  endfunction

  task automatic clear_name();
    name_pos = '0;
    stem_cnt = '0;
    stem_closed = 1'b0;
    for (int i = 0; i < 4; i++) stem[i] = '0;
    prior_byte = '0;
    lead_sep = 1'b0;
    colon_second = 1'b0;
    dot_run = 1'b0;
    bad_byte_seen = 1'b0;
  endtask

  task automatic scan_item(input in_item_t it);
    logic [7:0] c;
    logic [2:0] why;
    out_item_t  v;
    c = it.char_value;
    if (it.is_empty) begin
      clear_name();
      v.safe = 1'b0;
      v.reason = REASON_EMPTY;
      verdicts_due.push_back(v);
    end else begin
      if (name_pos == 0 && (c == CH_SLASH || c == CH_BSL)) lead_sep = 1'b1;
      if (name_pos == 1 && c == CH_COLON) colon_second = 1'b1;
      if (name_pos != 0 && prior_byte == CH_DOT && c == CH_DOT) dot_run = 1'b1;
      if (is_bad_byte(c)) bad_byte_seen = 1'b1;
      if (!stem_closed) begin
        if (c == CH_DOT) begin
          stem_closed = 1'b1;
        end else begin
          if (stem_cnt < 3'd4) stem[stem_cnt[1:0]] = c;
          if (stem_cnt < CNT_MAX) stem_cnt = stem_cnt + 3'd1;
        end
      end
      prior_byte = c;
      if (name_pos < CNT_MAX) name_pos = name_pos + 3'd1;
      if (it.last) begin
        if (c == CH_SPACE || c == CH_DOT) why = REASON_TRAILING;
        else if (lead_sep) why = REASON_LEAD_SEP;
        else if (colon_second) why = REASON_DRIVE;
        else if (dot_run) why = REASON_DOT_PAIR;
        else if (device_stem()) why = REASON_DEVICE;
        else if (bad_byte_seen) why = REASON_FORBIDDEN;
        else why = REASON_OK;
        clear_name();
        v.safe = (why == REASON_OK);
        v.reason = why;
        verdicts_due.push_back(v);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_name();
      verdicts_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict safe=%0b reason=%0d with none expected",
                                    out_data.safe, out_data.reason));
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.safe !== want.safe)
            report_mismatch($sformatf("safe %0b, expected %0b", out_data.safe, want.safe));
          if (out_data.reason !== want.reason)
            report_mismatch($sformatf("reason %0d, expected %0d",
                                      out_data.reason, want.reason));
        end
      end
      if (in_valid && !in_stall) scan_item(in_data);
    end
    verdicts_pending = verdicts_due.size();
  end

endmodule

/* tb/sv/filename_safety_checker_tb.sv */
// testbench top for the filename safety checker: drives names byte by byte in bursts,
// stalls the verdict channel on its own pattern and gives the final verdict
// depends on fsc_pkg, filename_safety_checker and fsc_verdict_checker
module filename_safety_checker_tb;
  import fsc_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT = 500000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        mismatches;
  int        verdicts_pending;

  int         cycles = 0;
  int         stall_mode = 0;
  int         mode_left = 0;
  int         burst_left = 0;
  int         items_sent = 0;
  logic [7:0] name_buf[$];
  string      name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-~";
  string      device_names = "CONPRNAUXNULCOMLPT";
  string      hazards = "/\\:. *\"<>|?";

  filename_safety_checker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  fsc_verdict_checker verdict_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .mismatches(mismatches), .verdicts_pending(verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(3);
      mode_left <= $urandom_range(200, 20);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(1) == 0);
      2: out_stall <= ($urandom_range(7) != 0);
      default: out_stall <= (mode_left % 8 < 5);
    endcase
  end

  function automatic in_item_t pack_item(input logic [7:0] c, input logic l, input logic e);
    in_item_t it;
    it.char_value = c;
    it.last = l;
    it.is_empty = e;
    return it;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7a && $urandom_range(1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255, 128));
    if ($urandom_range(19) == 0) return CH_SPACE;
    return name_chars[$urandom_range(name_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] hazard_char();
    case ($urandom_range(3))
      0: return 8'($urandom_range(31));
      1: return 8'($urandom_range(255));
      default: return hazards[$urandom_range(hazards.len() - 1)];
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_cycle();
    in_valid <= 1'b0;
    in_data <= in_item_t'($urandom);
    @(negedge clk);
  endtask

  task automatic put_byte(input in_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(3) != 0) repeat ($urandom_range(8, 1)) idle_cycle();
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    send_item(it);
    items_sent++;
  endtask

  task automatic drain();
    idle_cycle();
    while (verdicts_pending != 0) idle_cycle();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(pack_item(s[i], i == s.len() - 1, 1'b0));
  endtask

  task automatic make_name();
    int k;
    int at;
    name_buf.delete();
    case ($urandom_range(9))
      0, 1: begin
        k = $urandom_range(5);
        for (int i = 0; i < 3; i++) name_buf.push_back(flip_case(device_names[k * 3 + i]));
        if (k >= 4 || $urandom_range(5) == 0)
          name_buf.push_back($urandom_range(4) == 0 ? 8'h30 :
                             8'h30 + 8'($urandom_range(9, 1)));
        if ($urandom_range(4) == 0) void'(name_buf.pop_back());
        if ($urandom_range(5) == 0) name_buf.push_back(plain_char());
        if ($urandom_range(1)) begin
          name_buf.push_back(CH_DOT);
          repeat ($urandom_range(3, 1)) name_buf.push_back(plain_char());
        end
      end
      2, 3, 4: begin
        repeat ($urandom_range(10, 1))
          name_buf.push_back($urandom_range(5) == 0 ? CH_DOT : plain_char());
      end
      5: begin
        repeat ($urandom_range(8, 1)) name_buf.push_back(plain_char());
        at = $urandom_range(name_buf.size() - 1);
        name_buf[at] = hazard_char();
      end
      6: begin
        repeat ($urandom_range(6, 1)) name_buf.push_back(8'($urandom_range(255)));
      end
      7: begin
        repeat ($urandom_range(24, 8))
          name_buf.push_back($urandom_range(7) == 0 ? CH_DOT : plain_char());
      end
      8: begin
        case ($urandom_range(2))
          0: name_buf.push_back(CH_SLASH);
          1: name_buf.push_back(CH_BSL);
          default: begin
            name_buf.push_back(plain_char());
            name_buf.push_back(CH_COLON);
          end
        endcase
        repeat ($urandom_range(4)) name_buf.push_back(plain_char());
        if ($urandom_range(1)) begin
          name_buf.push_back(CH_DOT);
          name_buf.push_back(CH_DOT);
        end
        name_buf.push_back(plain_char());
      end
      default: ;
    endcase
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed names
    put_byte(pack_item(8'h00, 1'b1, 1'b1));
    send_text("a ");
    send_text("/");
    send_text("c:");
    send_text("..x");
    send_text("Nul");
    send_text("lpt9");
    put_byte(pack_item(8'h00, 1'b0, 1'b0));
    put_byte(pack_item(8'hff, 1'b1, 1'b0));
    put_byte(pack_item("a", 1'b0, 1'b0));
    put_byte(pack_item(8'hff, 1'b0, 1'b1));
    send_text("\\");
    send_text("Z");
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      make_name();
      if (name_buf.size() == 0) begin
        put_byte(pack_item(8'($urandom_range(255)), $urandom_range(3) != 0, 1'b1));
      end else if ($urandom_range(15) == 0) begin
        n = $urandom_range(name_buf.size() - 1);
        for (int i = 0; i < n; i++) put_byte(pack_item(name_buf[i], 1'b0, 1'b0));
        put_byte(pack_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1));
      end else begin
        for (int i = 0; i < name_buf.size(); i++)
          put_byte(pack_item(name_buf[i], i == name_buf.size() - 1, 1'b0));
      end
      if ($urandom_range(199) == 0) drain();
    end

    drain();
    repeat (8) idle_cycle();
    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
